// File: rtl/multitap_feedback_delay_macros.svh
// ----------------------------------------------------------------------------
// Multitap feedback delay assertion macros
// Shared property templates, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTITAP_FEEDBACK_DELAY_MACROS_SVH
`define MULTITAP_FEEDBACK_DELAY_MACROS_SVH

// same-cycle implication
`define MFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// Multitap feedback delay package
// Defaults, register indexes, control word layout and the microcode ROM.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int unsigned RING_DEPTH_DEF  = 131072;
  localparam int unsigned TAPS_DEF        = 4;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned FB_MAX  = 64880;
  localparam int unsigned MIX_ONE = 65536;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 33;
  localparam int unsigned DLY_W      = 17;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned TAP_REGS   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP0        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP1        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP2        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAP3        = 3'd6;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RD1  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RD2  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RD3  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL3 = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ACC3 = 4'd5;
  localparam logic [STEP_W-1:0] STEP_FB   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_WR   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_WET  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_OUT  = 4'd9;

  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_IN     = 2'd1,
    COND_OUT    = 2'd2
  } cond_t;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_TAP  = 3'd1,
    MUL_FB   = 3'd2,
    MUL_DRY  = 3'd3,
    MUL_WET  = 3'd4
  } mul_sel_t;

  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] nxt;
    logic              rd_en;
    logic [1:0]        rd_tap;
    mul_sel_t          mul_sel;
    logic [1:0]        mul_tap;
    logic              acc_en;
    logic              wr_en;
    logic              dry_save;
    logic              out_load;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w         = '0;
    w.cond    = COND_ALWAYS;
    w.mul_sel = MUL_NONE;
    w.nxt     = STEP_IDLE;
    case (step)
      STEP_IDLE: begin
        w.cond = COND_IN; w.nxt = STEP_RD1;
        w.rd_en = 1'b1; w.rd_tap = 2'd0;
      end
      STEP_RD1: begin
        w.nxt = STEP_RD2;
        w.rd_en = 1'b1; w.rd_tap = 2'd1;
        w.mul_sel = MUL_TAP; w.mul_tap = 2'd0;
      end
      STEP_RD2: begin
        w.nxt = STEP_RD3;
        w.rd_en = 1'b1; w.rd_tap = 2'd2;
        w.mul_sel = MUL_TAP; w.mul_tap = 2'd1; w.acc_en = 1'b1;
      end
      STEP_RD3: begin
        w.nxt = STEP_MUL3;
        w.rd_en = 1'b1; w.rd_tap = 2'd3;
        w.mul_sel = MUL_TAP; w.mul_tap = 2'd2; w.acc_en = 1'b1;
      end
      STEP_MUL3: begin
        w.nxt = STEP_ACC3;
        w.mul_sel = MUL_TAP; w.mul_tap = 2'd3; w.acc_en = 1'b1;
      end
      STEP_ACC3: begin
        w.nxt = STEP_FB; w.acc_en = 1'b1;
      end
      STEP_FB: begin
        w.nxt = STEP_WR; w.mul_sel = MUL_FB;
      end
      STEP_WR: begin
        w.nxt = STEP_WET; w.wr_en = 1'b1; w.mul_sel = MUL_DRY;
      end
      STEP_WET: begin
        w.nxt = STEP_OUT; w.dry_save = 1'b1; w.mul_sel = MUL_WET;
      end
      STEP_OUT: begin
        w.cond = COND_OUT; w.nxt = STEP_IDLE; w.out_load = 1'b1;
      end
      default: begin
        w.nxt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/multitap_feedback_delay.sv
// Flow: an input beat taken in IDLE steps through RD1-RD3, MUL3, ACC3, FB, WR,
// WET and OUT, which sets out_valid once the output is free; the next sample is
// taken only back in IDLE. One ring port serves four tap reads and one write per
// sample, one shared multiplier does all products. Reset: synchronous, active low;
// clears control, config and the ring fill count at once, so unwritten ring entries read as zero without a clear pass.
// ----------------------------------------------------------------------------
// Multitap feedback delay
// Microcoded delay ring with up to four weighted taps, feedback and dry/wet mix.
// ----------------------------------------------------------------------------
`include "multitap_feedback_delay_macros.svh"

module multitap_feedback_delay
  import mfd_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned TAPS        = TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CW    = (DLY_W > PTR_W + 1) ? DLY_W + 1 : PTR_W + 2;
  localparam int unsigned ACC_W = SB + 18;
  localparam int unsigned OPB_W = 18;
  localparam int unsigned MUL_W = ACC_W + OPB_W;
  localparam int unsigned RW    = MUL_W + 1;
  localparam int unsigned QW    = RW - 31;
  localparam logic signed [RW-1:0] RND = RW'(1) <<< 30;
  localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
  localparam logic [CW-1:0] DMAX_C  = CW'(RING_DEPTH - 1);

  // config
  logic [2:0]            active_taps_r;
  logic [15:0]           fb_r;
  logic [16:0]           mix_r;
  logic [CFG_DATA_W-1:0] tap_r [TAP_REGS];

  // sequencer / datapath
  logic [STEP_W-1:0]       step_r, step_nxt;
  ctrl_t                   ctrl;
  logic                    go;
  logic [PTR_W-1:0]        wi_r;
  logic                    full_r;
  logic signed [SB-1:0]    x_r;
  logic [SB-1:0]           ram_q_r;
  logic                    rd_ok_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [MUL_W-1:0] mul_r;
  logic signed [MUL_W-1:0] dry_r;
  logic                    out_valid_r;
  logic signed [SB-1:0]    out_sample_r;

  logic [SB-1:0]           ring_mem [RING_DEPTH];

  logic [2:0]              n_taps;
  logic [15:0]             fb_c;
  logic [16:0]             mix_c;
  logic [CW-1:0]           d_raw, d_cl, wi_ext, rp;
  logic [PTR_W-1:0]        rd_addr;
  logic signed [ACC_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  logic [GAIN_W-1:0]       gain;
  logic signed [RW-1:0]    ring_acc, out_acc;
  logic [SB-1:0]           ring_val;
  logic signed [SB-1:0]    out_val;

  function automatic logic [SB-1:0] round_sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] t;
    logic [QW-1:0]        q;
    logic [QW-SB:0]       top;
    t   = v + RND;
    q   = t[RW-1:31];
    top = q[QW-1:SB-1];
    if ((&top) || !(|top)) begin
      return q[SB-1:0];
    end else if (q[QW-1]) begin
      return {1'b1, {(SB-1){1'b0}}};
    end else begin
      return {1'b0, {(SB-1){1'b1}}};
    end
  endfunction

  assign ctrl = ucode(step_r);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS: go = 1'b1;
      COND_IN:     go = in_valid;
      COND_OUT:    go = !out_valid_r || out_ready;
      default:     go = 1'b1;
    endcase
    step_nxt = go ? ctrl.nxt : step_r;
  end

  assign in_ready       = (ctrl.cond == COND_IN);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  assign n_taps = (active_taps_r > 3'(TAPS)) ? 3'(TAPS) : active_taps_r;
  assign fb_c   = (fb_r > 16'(FB_MAX)) ? 16'(FB_MAX) : fb_r;
  assign mix_c  = (mix_r > 17'(MIX_ONE)) ? 17'(MIX_ONE) : mix_r;

  // tap read address: wi - clamp(delay) modulo depth
  always_comb begin
    d_raw  = CW'(tap_r[ctrl.rd_tap][CFG_DATA_W-1:GAIN_W]);
    wi_ext = CW'(wi_r);
    if (d_raw == '0) begin
      d_cl = CW'(1);
    end else if (d_raw >= DEPTH_C) begin
      d_cl = DMAX_C;
    end else begin
      d_cl = d_raw;
    end
    if (wi_ext >= d_cl) begin
      rp = wi_ext - d_cl;
    end else begin
      rp = wi_ext + DEPTH_C - d_cl;
    end
    rd_addr = rp[PTR_W-1:0];
  end

  // shared multiplier operands
  always_comb begin
    gain = tap_r[ctrl.mul_tap][GAIN_W-1:0];
    case (ctrl.mul_sel)
      MUL_TAP: begin
        opa = rd_ok_r ? ACC_W'($signed(ram_q_r)) : '0;
        opb = ({1'b0, ctrl.mul_tap} < n_taps) ? OPB_W'($signed(gain)) : '0;
      end
      MUL_FB: begin
        opa = acc_r;
        opb = $signed({2'b00, fb_c});
      end
      MUL_DRY: begin
        opa = ACC_W'(x_r);
        opb = $signed({1'b0, 17'(17'(MIX_ONE) - mix_c)});
      end
      MUL_WET: begin
        opa = acc_r;
        opb = $signed({1'b0, mix_c});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign ring_acc = (RW'(x_r) <<< 31) + RW'(mul_r);
  assign out_acc  = (RW'(dry_r) <<< 15) + RW'(mul_r);
  assign ring_val = round_sat(ring_acc);
  assign out_val  = $signed(round_sat(out_acc));

  // ring memory, single port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      ring_mem[wi_r] <= ring_val;
    end
    if (ctrl.rd_en) begin
      ram_q_r <= ring_mem[rd_addr];
      rd_ok_r <= full_r || (rd_addr < wi_r);
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r   <= in_sample_in;
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + $signed(mul_r[ACC_W-1:0]);
    end
    if (ctrl.mul_sel != MUL_NONE) begin
      mul_r <= MUL_W'(opa) * MUL_W'(opb);
    end
    if (ctrl.dry_save) begin
      dry_r <= mul_r;
    end
    if (ctrl.out_load && go) begin
      out_sample_r <= out_val;
    end
  end

  // control and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= STEP_IDLE;
      wi_r          <= '0;
      full_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      active_taps_r <= '0;
      fb_r          <= '0;
      mix_r         <= '0;
      for (int i = 0; i < TAP_REGS; i++) begin
        tap_r[i] <= '0;
      end
    end else begin
      step_r <= step_nxt;
      if (ctrl.wr_en) begin
        if (wi_r == PTR_W'(RING_DEPTH - 1)) begin
          wi_r   <= '0;
          full_r <= 1'b1;
        end else begin
          wi_r <= wi_r + PTR_W'(1);
        end
      end
      if (ctrl.out_load && go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE_TAPS: active_taps_r <= cfg_wdata[2:0];
          REG_FEEDBACK:    fb_r          <= cfg_wdata[15:0];
          REG_WET_MIX:     mix_r         <= cfg_wdata[16:0];
          REG_TAP0:        tap_r[0]      <= cfg_wdata;
          REG_TAP1:        tap_r[1]      <= cfg_wdata;
          REG_TAP2:        tap_r[2]      <= cfg_wdata;
          REG_TAP3:        tap_r[3]      <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  `MFD_ASSERT_NOW(a_step_range, 1'b1, step_r <= STEP_OUT, "step counter out of program")
  `MFD_ASSERT_NXT(a_accept_step, in_valid && in_ready, step_r == STEP_RD1,
                  "sequencer did not start after input beat")
  `MFD_ASSERT_NXT(a_wr_advance, ctrl.wr_en, wi_r != $past(wi_r), "write pointer stuck")
  `MFD_ASSERT_NXT(a_full_sticky, full_r, full_r, "ring fill flag dropped")
  `MFD_ASSERT_NOW(a_no_overwrite, ctrl.out_load && go, !out_valid_r || out_ready,
                  "pending output beat overwritten")

endmodule
